[src/rss_pkg.sv]
// rss_pkg: shared types and constants of the record selection sorter
// record layout, beat structs, key select codes and register indexes
// no dependencies
package rss_pkg;

    // bytes of each text key that take part in a compare (top bytes first)
    localparam int TEXT_BYTES = 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KEY_FIELD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ASCENDING = 1'b1;

    // sort key select codes
    localparam int KEY_W = 3;
    localparam logic [KEY_W-1:0] KEY_LETTER      = 3'd0;
    localparam logic [KEY_W-1:0] KEY_INT         = 3'd1;
    localparam logic [KEY_W-1:0] KEY_SHORT       = 3'd2;
    localparam logic [KEY_W-1:0] KEY_FIRST_TEXT  = 3'd3;
    localparam logic [KEY_W-1:0] KEY_SECOND_TEXT = 3'd4;

    // one stored record
    typedef struct packed {
        logic signed [7:0]  letter;
        logic signed [31:0] int_value;
        logic signed [15:0] short_value;
        logic [63:0]        first_text;
        logic [63:0]        second_text;
    } rec_t;

    // input beat
    typedef struct packed {
        logic signed [7:0]  letter;
        logic signed [31:0] int_value;
        logic signed [15:0] short_value;
        logic [63:0]        first_text;
        logic [63:0]        second_text;
        logic               last_record;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic signed [7:0]  out_letter;
        logic signed [31:0] out_int_value;
        logic signed [15:0] out_short_value;
        logic [63:0]        out_first_text;
        logic [63:0]        out_second_text;
        logic               final_result;
    } out_beat_t;

    // sort settings seen by the compare unit
    typedef struct packed {
        logic [KEY_W-1:0] key_field;
        logic             ascending;
    } sort_cfg_t;

endpackage

[src/rss_ram.sv]
// rss_ram: generic single write port, single read port memory
// read data is registered; no dependencies
module rss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/rss_key_cmp.sv]
// rss_key_cmp: compare unit of the sorter, decides whether a candidate beats the best so far
// uses rss_pkg (record type, key codes, text key length)
module rss_key_cmp import rss_pkg::*; (
    input  sort_cfg_t cfg,
    input  rec_t      cand,
    input  rec_t      best,
    output logic      better
);

    // text key: flip each byte's sign bit so signed bytewise order becomes unsigned order
    function automatic logic [63:0] text_key(input logic [63:0] t);
        logic [63:0] k;
        k = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < TEXT_BYTES) begin
                k[63-8*b -: 8] = {~t[63-8*b], t[62-8*b -: 7]};
            end
        end
        return k;
    endfunction

    // map the selected field to an unsigned order key; unknown selector gives all equal
    function automatic logic [63:0] order_key(input rec_t r, input logic [KEY_W-1:0] sel);
        logic [63:0] k;
        k = '0;
        unique case (sel)
            KEY_LETTER:      k = {56'd0, ~r.letter[7], r.letter[6:0]};
            KEY_INT:         k = {32'd0, ~r.int_value[31], r.int_value[30:0]};
            KEY_SHORT:       k = {48'd0, ~r.short_value[15], r.short_value[14:0]};
            KEY_FIRST_TEXT:  k = text_key(r.first_text);
            KEY_SECOND_TEXT: k = text_key(r.second_text);
            default:         k = '0;
        endcase
        return k;
    endfunction

    logic [63:0] cand_key;
    logic [63:0] best_key;

    // one wide compare, direction picked by the sort order
    always_comb begin
        cand_key = order_key(cand, cfg.key_field);
        best_key = order_key(best, cfg.key_field);
        better   = cfg.ascending ? (cand_key < best_key) : (cand_key > best_key);
    end

endmodule

[src/record_selection_sorter.sv]
// record_selection_sorter: top level, loads a record set and emits it sorted by a chosen key
// uses rss_pkg, rss_ram (record memory) and rss_key_cmp (compare unit)
//
// Records are loaded one beat per cycle into a MAX_RECORDS deep memory; a beat that arrives
// with the memory full is dropped. The beat marked last_record starts the sort, and s_ready
// stays low until the last sorted record has been handed to the output register. The sort is
// a selection sort run on one compare unit fed by the single memory read port, one candidate
// per cycle. Each slot's winner leaves once its scan is done and the output register is free,
// and final_result marks the last one of the set.
module record_selection_sorter import rss_pkg::*; #(
    parameter int MAX_RECORDS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int IW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

    typedef enum logic [4:0] {
        ST_LOAD     = 5'b00001,
        ST_SLOT_RD  = 5'b00010,
        ST_SLOT_CAP = 5'b00100,
        ST_SCAN     = 5'b01000,
        ST_EMIT     = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   slot_reg, slot_next;
    logic [IW-1:0]   scan_reg, scan_next;
    logic [IW-1:0]   best_idx_reg, best_idx_next;
    rec_t            cur_reg, cur_next;
    rec_t            best_reg, best_next;
    out_beat_t       out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    sort_cfg_t       cfg_reg, cfg_next;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    rec_t            ram_wdata;
    logic [IW-1:0]   ram_raddr;
    rec_t            ram_rdata;

    rec_t            in_rec;
    logic [CW-1:0]   slot_inc;
    logic [CW-1:0]   scan_inc;
    logic            slot_last;
    logic            scan_last;
    logic            out_free;
    logic            better;

    // record memory
    rss_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (MAX_RECORDS)
    ) u_rss_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare unit: memory read data against the best record so far
    rss_key_cmp u_rss_key_cmp (
        .cfg    (cfg_reg),
        .cand   (ram_rdata),
        .best   (best_reg),
        .better (better)
    );

    // input record and index arithmetic
    always_comb begin
        in_rec.letter      = s_data.letter;
        in_rec.int_value   = s_data.int_value;
        in_rec.short_value = s_data.short_value;
        in_rec.first_text  = s_data.first_text;
        in_rec.second_text = s_data.second_text;
        slot_inc  = CW'(slot_reg) + CW'(1);
        scan_inc  = CW'(scan_reg) + CW'(1);
        slot_last = (slot_inc == cnt_reg);
        scan_last = (scan_inc == cnt_reg);
        out_free  = !out_valid_reg || m_ready;
    end

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDX_KEY_FIELD: cfg_next.key_field = cfg_wr_data[KEY_W-1:0];
                CFG_IDX_ASCENDING: cfg_next.ascending = cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // load and sort sequencer
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        scan_next      = scan_reg;
        best_idx_next  = best_idx_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        ram_we         = 1'b0;
        ram_waddr      = best_idx_reg;
        ram_wdata      = cur_reg;
        ram_raddr      = slot_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (cnt_reg != MAX_CNT) begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[IW-1:0];
                        ram_wdata = in_rec;
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    if (s_data.last_record) begin
                        slot_next  = '0;
                        state_next = ST_SLOT_RD;
                    end
                end
            end
            ST_SLOT_RD: begin
                ram_raddr  = slot_reg;
                state_next = ST_SLOT_CAP;
            end
            ST_SLOT_CAP: begin
                // slot record is the first candidate; start reading the rest
                cur_next      = ram_rdata;
                best_next     = ram_rdata;
                best_idx_next = slot_reg;
                scan_next     = slot_inc[IW-1:0];
                ram_raddr     = slot_inc[IW-1:0];
                state_next    = slot_last ? ST_EMIT : ST_SCAN;
            end
            ST_SCAN: begin
                // keep the first strictly better key
                if (better) begin
                    best_next     = ram_rdata;
                    best_idx_next = scan_reg;
                end
                ram_raddr = scan_inc[IW-1:0];
                scan_next = scan_inc[IW-1:0];
                if (scan_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // slot is final: send the winner, move the slot record to its place
                if (out_free) begin
                    out_next.out_letter      = best_reg.letter;
                    out_next.out_int_value   = best_reg.int_value;
                    out_next.out_short_value = best_reg.short_value;
                    out_next.out_first_text  = best_reg.first_text;
                    out_next.out_second_text = best_reg.second_text;
                    out_next.final_result    = slot_last;
                    out_valid_next           = 1'b1;
                    ram_we                   = 1'b1;
                    if (slot_last) begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        slot_next  = slot_inc[IW-1:0];
                        state_next = ST_SLOT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_LOAD;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
            cfg_reg.key_field <= KEY_FIRST_TEXT;
            cfg_reg.ascending <= 1'b1;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    // payload and index registers
    always_ff @(posedge aclk) begin
        slot_reg     <= slot_next;
        scan_reg     <= scan_next;
        best_idx_reg <= best_idx_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        out_reg      <= out_next;
    end

endmodule

[src/rss_checker.sv]
// rss_checker: port level checks of the record selection sorter, bound to the top level
// uses rss_pkg (beat types)
module rss_checker import rss_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // the last beat of a set closes the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last_record |=> !s_ready)
        else $error("input open after last beat of a set");

    // a beat that is not last keeps the input open
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.last_record |=> s_ready)
        else $error("input closed after a loading beat");

    // non-final results only come out while the input is closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.final_result |-> !s_ready)
        else $error("input open while a set is still being sent");

    // the input reopens together with the final result of the set
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_ready) |-> m_valid && m_data.final_result)
        else $error("input reopened without the final result");

endmodule

bind record_selection_sorter rss_checker u_rss_checker (.*);

[sim/record_selection_sorter_tb.sv]
`timescale 1ns / 1ps
// record_selection_sorter_tb: self-checking testbench for the record selection sorter
// loads record sets, predicts the sorted order with a scoreboard class and checks each result beat
// depends on rss_pkg and record_selection_sorter
import rss_pkg::*;

// tracks loaded records and holds the sorted beats still owed by the block
class sorted_record_tracker;
    localparam int HELD_MAX = 16;

    rec_t             held[HELD_MAX];
    int unsigned      held_count;
    logic [KEY_W-1:0] key_sel;
    bit               smallest_first;
    out_beat_t        pending_sorted[$];
    int unsigned      mismatches;

    function new();
        held_count     = 0;
        key_sel        = KEY_FIRST_TEXT;
        smallest_first = 1'b1;
        mismatches     = 0;
    endfunction

    function int order_nums(longint x, longint y);
        return (x < y) ? -1 : ((x > y) ? 1 : 0);
    endfunction

    // bytewise signed compare, first character in the top byte
    function int order_texts(logic [63:0] a, logic [63:0] b);
        byte x;
        byte y;
        for (int k = 0; k < TEXT_BYTES; k++) begin
            x = a[63-8*k -: 8];
            y = b[63-8*k -: 8];
            if (x != y)
                return (x < y) ? -1 : 1;
        end
        return 0;
    endfunction

    function int order_records(rec_t a, rec_t b);
        case (key_sel)
            KEY_LETTER:      return order_nums(a.letter, b.letter);
            KEY_INT:         return order_nums(a.int_value, b.int_value);
            KEY_SHORT:       return order_nums(a.short_value, b.short_value);
            KEY_FIRST_TEXT:  return order_texts(a.first_text, b.first_text);
            KEY_SECOND_TEXT: return order_texts(a.second_text, b.second_text);
            default:         return 0;
        endcase
    endfunction

    // store an accepted beat; the last one of a set sorts and queues the whole set
    function void note_record(in_beat_t beat);
        int unsigned best;
        int          c;
        rec_t        tmp;
        out_beat_t   o;
        if (held_count < HELD_MAX) begin
            held[held_count] = '{beat.letter, beat.int_value, beat.short_value,
                                 beat.first_text, beat.second_text};
            held_count++;
        end
        if (!beat.last_record)
            return;
        // selection sort, first strictly better candidate wins
        for (int j = 0; j < held_count; j++) begin
            best = j;
            for (int i = j + 1; i < held_count; i++) begin
                c = order_records(held[i], held[best]);
                if (smallest_first ? (c < 0) : (c > 0))
                    best = i;
            end
            if (best != j) begin
                tmp        = held[j];
                held[j]    = held[best];
                held[best] = tmp;
            end
        end
        for (int j = 0; j < held_count; j++) begin
            o.out_letter      = held[j].letter;
            o.out_int_value   = held[j].int_value;
            o.out_short_value = held[j].short_value;
            o.out_first_text  = held[j].first_text;
            o.out_second_text = held[j].second_text;
            o.final_result    = (j + 1 == held_count);
            pending_sorted.push_back(o);
        end
        held_count = 0;
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    function void check_emitted(out_beat_t got);
        out_beat_t exp_b;
        if (pending_sorted.size() == 0) begin
            $error("result beat with nothing expected: %0h", got);
            mismatches++;
            return;
        end
        exp_b = pending_sorted.pop_front();
        compare_field("out_letter", exp_b.out_letter, got.out_letter);
        compare_field("out_int_value", exp_b.out_int_value, got.out_int_value);
        compare_field("out_short_value", exp_b.out_short_value, got.out_short_value);
        compare_field("out_first_text", exp_b.out_first_text, got.out_first_text);
        compare_field("out_second_text", exp_b.out_second_text, got.out_second_text);
        compare_field("final_result", exp_b.final_result, got.final_result);
    endfunction
endclass

module record_selection_sorter_tb;

    localparam int CLK_HALF       = 1;
    // overall time limit of the run, in ns
    localparam int LIMIT_NS       = 400000;
    localparam int RANDOM_RECORDS = 85;
    localparam int DRAIN_CAP      = 20000;
    localparam int IDLE_GAP       = 20;
    localparam int TAIL_CYCLES    = 200;
    localparam int LONG_HOLD      = 400;
    localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}};
    localparam bit ORDER_ASC  = 1'b1;
    localparam bit ORDER_DESC = 1'b0;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    out_beat_t             m_data;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    sorted_record_tracker tracker = new();
    in_beat_t    staged_set[$];
    int unsigned burst_left   = 0;
    bit          sender_gaps  = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned stall_pct    = 0;
    int unsigned stall_phase  = 0;
    int unsigned random_sent  = 0;

    record_selection_sorter DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // result side: check accepted beats, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_emitted(m_data);
        if (stall_phase == 0) begin
            case ($urandom_range(0, 4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 30;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        stall_phase = (stall_phase + 1) % 48;
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // text key: mostly short strings over a tiny alphabet so prefixes and ties show up
    function automatic logic [63:0] rand_text();
        logic [63:0] t;
        int unsigned len;
        t = '0;
        if ($urandom_range(0, 4) == 0)
            return {$urandom, $urandom};
        len = $urandom_range(0, 8);
        for (int k = 0; k < len; k++)
            t[63-8*k -: 8] = ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                         : 8'(8'h61 + $urandom_range(0, 2));
        return t;
    endfunction

    function automatic in_beat_t rand_record();
        in_beat_t r;
        r.letter      = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        r.int_value   = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
        r.short_value = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 3))
                                                    : 16'($urandom);
        r.first_text  = rand_text();
        r.second_text = rand_text();
        r.last_record = 1'b0;
        return r;
    endfunction

    function automatic void stage_records(int unsigned n);
        repeat (n) staged_set.push_back(rand_record());
    endfunction

    // one input beat, with burst gaps in front of it
    task automatic send_record(input in_beat_t beat);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (sender_gaps) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        tracker.note_record(beat);
    endtask

    task automatic send_set();
        staged_set[staged_set.size()-1].last_record = 1'b1;
        foreach (staged_set[i])
            send_record(staged_set[i]);
        staged_set.delete();
    endtask

    task automatic wait_drained();
        int unsigned waited;
        waited = 0;
        while (tracker.pending_sorted.size() != 0 && waited < DRAIN_CAP) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    // stop sending and let every owed beat come out
    task automatic settle_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        wait_drained();
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    // both registers, back to back, only while idle
    task automatic configure(input logic [KEY_W-1:0] key, input bit order);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_IDX_KEY_FIELD;
        cfg_wr_data <= CFG_DATA_W'(key);
        @(posedge aclk);
        cfg_index   <= CFG_IDX_ASCENDING;
        cfg_wr_data <= CFG_DATA_W'(order);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.key_sel        = key;
        tracker.smallest_first = order;
    endtask

    initial begin
        #(LIMIT_NS);
        $display("record_selection_sorter_tb NOT OK");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: first text, ascending; signed bytes, prefixes, padding
        stage_records(6);
        staged_set[0].first_text = 64'h8000_0000_0000_0000;
        staged_set[1].first_text = 64'h6170_706C_6500_0000;
        staged_set[2].first_text = 64'h6170_706C_7900_0000;
        staged_set[3].first_text = 64'hFFFF_FFFF_FFFF_FFFF;
        staged_set[4].first_text = 64'h7F7F_7F7F_7F7F_7F7F;
        staged_set[5].first_text = 64'h0;
        send_set();

        // integer extremes
        settle_idle();
        configure(KEY_INT, ORDER_ASC);
        stage_records(4);
        staged_set[0].int_value = 32'h7FFF_FFFF;
        staged_set[1].int_value = 32'h8000_0000;
        staged_set[2].int_value = 32'hFFFF_FFFF;
        staged_set[3].int_value = 32'h0;
        send_set();

        // short extremes with equal keys, largest first
        settle_idle();
        configure(KEY_SHORT, ORDER_DESC);
        stage_records(4);
        staged_set[0].short_value = 16'h8000;
        staged_set[1].short_value = 16'd5;
        staged_set[2].short_value = 16'h7FFF;
        staged_set[3].short_value = 16'd5;
        send_set();

        settle_idle();
        configure(KEY_LETTER, ORDER_DESC);
        stage_records(3);
        staged_set[0].letter = 8'h80;
        staged_set[1].letter = 8'h7F;
        staged_set[2].letter = 8'h7F;
        send_set();

        // second text differing only in the last byte
        settle_idle();
        configure(KEY_SECOND_TEXT, ORDER_ASC);
        stage_records(3);
        staged_set[0].second_text = 64'h6161_6161_6161_6101;
        staged_set[1].second_text = 64'h6161_6161_6161_61FF;
        staged_set[2].second_text = 64'h6161_6161_6161_6101;
        send_set();

        // unused key code: everything ties, load order comes back
        settle_idle();
        configure(KEY_TOP, ORDER_DESC);
        stage_records(3);
        send_set();
        stage_records(1);
        send_set();

        // long output hold while a full set plus a dropped last beat and another set are offered
        settle_idle();
        configure(KEY_INT, ORDER_DESC);
        hold_request = 1'b1;
        sender_gaps  = 1'b0;
        stage_records(17);
        send_set();
        stage_records(5);
        send_set();
        settle_idle();

        // random sets, settings changed only between drained sets
        while (random_sent < RANDOM_RECORDS) begin
            int unsigned n;
            if ($urandom_range(0, 1) == 0) begin
                settle_idle();
                configure(KEY_W'($urandom_range(0, KEY_TOP)), 1'($urandom_range(0, 1)));
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
            sender_gaps = ($urandom_range(0, 3) != 0);
            stage_records(n);
            send_set();
            random_sent += n;
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.pending_sorted.size() != 0) begin
            $error("%0d sorted beats never came out", tracker.pending_sorted.size());
            tracker.mismatches += tracker.pending_sorted.size();
        end
        if (tracker.mismatches == 0) begin
            $display("record_selection_sorter_tb OK");
        end else begin
            $display("record_selection_sorter_tb NOT OK");
        end
        $finish;
    end

endmodule
